>>> src/mouse_driver_state_tracker_core_defines.svh
// assertion macros for the mouse state tracker checker
// used only by the checker file; no other dependencies
`ifndef MOUSE_DRIVER_STATE_TRACKER_CORE_DEFINES_SVH
`define MOUSE_DRIVER_STATE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define MDST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdst check failed");

// next-cycle implication, ignored while reset is asserted
`define MDST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdst check failed");

`endif

>>> src/mdst_pkg.sv
// shared types and constants for the mouse state tracker
// no dependencies
`default_nettype none

package mdst_pkg;

    // command codes
    localparam logic [2:0] CMD_EVENT      = 3'd0;
    localparam logic [2:0] CMD_RESET      = 3'd1;
    localparam logic [2:0] CMD_SHOW       = 3'd2;
    localparam logic [2:0] CMD_HIDE       = 3'd3;
    localparam logic [2:0] CMD_READ_POS   = 3'd4;
    localparam logic [2:0] CMD_READ_PRESS = 3'd5;
    localparam logic [2:0] CMD_READ_MOTION = 3'd6;

    // event mask bit positions
    localparam int EV_LEFT_DOWN   = 1;
    localparam int EV_LEFT_UP     = 2;
    localparam int EV_RIGHT_DOWN  = 3;
    localparam int EV_RIGHT_UP    = 4;
    localparam int EV_MIDDLE_DOWN = 5;
    localparam int EV_MIDDLE_UP   = 6;

    // button bit positions
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_MIDDLE = 2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_HORIZ_RATIO = 2'd0;
    localparam logic [1:0] REG_VERT_RATIO  = 2'd1;
    localparam logic [1:0] REG_CALL_MASK   = 2'd2;

    // register reset values
    localparam logic [15:0] HORIZ_RATIO_RST = 16'd8;
    localparam logic [15:0] VERT_RATIO_RST  = 16'd16;
    localparam logic [6:0]  CALL_MASK_RST   = 7'd0;

    // driver reset answer and hide counter values
    localparam logic [15:0] RESET_ANSWER_A = 16'hFFFF;
    localparam logic [15:0] BUTTON_COUNT   = 16'd3;
    localparam logic [15:0] HIDE_RST       = 16'd1;
    localparam logic [15:0] HIDE_MAX       = 16'hFFFF;

    // ratio fraction bits (ratio is used divided by 8)
    localparam int RATIO_SHIFT = 3;
    localparam int MUL_W       = 16 - RATIO_SHIFT;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [6:0]  event_mask;
        logic        button_select;
    } evt_item_t;

    typedef struct packed {
        logic [15:0] reg_a;
        logic [15:0] reg_b;
        logic [15:0] reg_c;
        logic [15:0] reg_d;
        logic        cursor_shown;
        logic        call_request;
        logic [6:0]  call_mask;
        logic [2:0]  call_buttons;
        logic [15:0] call_x;
        logic [15:0] call_y;
        logic [15:0] call_mickey_x;
        logic [15:0] call_mickey_y;
    } res_item_t;

    typedef struct packed {
        logic [15:0] horiz_ratio;
        logic [15:0] vert_ratio;
        logic [6:0]  call_mask;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/mouse_driver_state_tracker_core.sv
// Three-button mouse driver state tracker.
// Input channel evt_*: one beat is one command or mouse event (evt_item).
// Output channel res_*: exactly one result beat (res_item) per input beat, in order.
// Config: apb port, horiz_ratio at 0x0, vert_ratio at 0x4, event_call_mask at 0x8;
// write only while no item is in flight.
// Flow: an accepted beat lands in the input register; when the output side is free
// its result is computed and captured in the result register, which drives res_valid.
// Throughput: one beat per cycle while res_stall is low; the state update and one
// 16x13 multiply per axis sit between the input register and the result register.
// Reset: clears the pipeline and the driver state (hide counter to 1) and loads the
// register defaults. The driver reset command clears the state but not the registers.
// Stall: a held result keeps its payload; the input register still takes one more
// beat, and evt_stall rises only when both registers are full.
// depends on mdst_pkg, mdst_cfg, mdst_track
`default_nettype none

module mouse_driver_state_tracker_core
    import mdst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        evt_valid,
    output logic             evt_stall,
    input  evt_item_t        evt_item,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_item_t        res_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t      cfg;
    evt_item_t in_item_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    res_item_t out_item_reg;
    res_item_t res_comb;
    logic      out_free;
    logic      go;
    logic      take;

    // handshake control
    assign out_free  = !out_valid_reg || !res_stall;
    assign go        = in_valid_reg && out_free;
    assign evt_stall = in_valid_reg && !out_free;
    assign take      = evt_valid && !evt_stall;
    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    mdst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdst_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= evt_item;
        end
        if (go)
        begin
            out_item_reg <= res_comb;
        end
    end

endmodule

`default_nettype wire

>>> src/mdst_cfg.sv
// configuration register file behind the apb port
// depends on mdst_pkg
`default_nettype none

module mdst_cfg
    import mdst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.horiz_ratio <= HORIZ_RATIO_RST;
            cfg_reg.vert_ratio  <= VERT_RATIO_RST;
            cfg_reg.call_mask   <= CALL_MASK_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_HORIZ_RATIO)
            begin
                cfg_reg.horiz_ratio <= pwdata[15:0];
            end
            if (reg_idx == REG_VERT_RATIO)
            begin
                cfg_reg.vert_ratio <= pwdata[15:0];
            end
            if (reg_idx == REG_CALL_MASK)
            begin
                cfg_reg.call_mask <= pwdata[6:0];
            end
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_HORIZ_RATIO: prdata = {16'b0, cfg_reg.horiz_ratio};
            REG_VERT_RATIO:  prdata = {16'b0, cfg_reg.vert_ratio};
            REG_CALL_MASK:   prdata = {25'b0, cfg_reg.call_mask};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/mdst_track.sv
// driver state registers and the single-pass update and result logic
// depends on mdst_pkg
`default_nettype none

module mdst_track
    import mdst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      go,
    input  evt_item_t      item,
    input  cfg_t           cfg,
    output res_item_t      res
);

    logic [15:0] cur_x_reg, cur_x_next;
    logic [15:0] cur_y_reg, cur_y_next;
    logic [2:0]  buttons_reg, buttons_next;
    logic [15:0] left_cnt_reg, left_cnt_next;
    logic [15:0] right_cnt_reg, right_cnt_next;
    logic [15:0] left_x_reg, left_x_next;
    logic [15:0] left_y_reg, left_y_next;
    logic [15:0] right_x_reg, right_x_next;
    logic [15:0] right_y_reg, right_y_next;
    logic [15:0] prev_x_reg, prev_x_next;
    logic [15:0] prev_y_reg, prev_y_next;
    logic [15:0] hide_reg, hide_next;

    logic [MUL_W-1:0]    hm;
    logic [MUL_W-1:0]    vm;
    logic [15:0]         mul_x_a;
    logic [15:0]         mul_y_a;
    logic [MUL_W+15:0]   prod_x;
    logic [MUL_W+15:0]   prod_y;
    logic [6:0]          em;
    logic [6:0]          hit;
    logic [2:0]          btn_evt;

    assign em  = item.event_mask;
    assign hm  = cfg.horiz_ratio[15:RATIO_SHIFT];
    assign vm  = cfg.vert_ratio[15:RATIO_SHIFT];
    assign hit = em & cfg.call_mask;

    // one multiplier per axis: event position or motion delta
    assign mul_x_a = (item.command == CMD_EVENT) ? item.pos_x : 16'(cur_x_reg - prev_x_reg);
    assign mul_y_a = (item.command == CMD_EVENT) ? item.pos_y : 16'(cur_y_reg - prev_y_reg);
    assign prod_x  = {{MUL_W{1'b0}}, mul_x_a} * {16'b0, hm};
    assign prod_y  = {{MUL_W{1'b0}}, mul_y_a} * {16'b0, vm};

    // button edges: down first, then up
    always_comb
    begin
        btn_evt             = buttons_reg;
        btn_evt[BTN_LEFT]   = (btn_evt[BTN_LEFT] | em[EV_LEFT_DOWN]) & ~em[EV_LEFT_UP];
        btn_evt[BTN_RIGHT]  = (btn_evt[BTN_RIGHT] | em[EV_RIGHT_DOWN]) & ~em[EV_RIGHT_UP];
        btn_evt[BTN_MIDDLE] = (btn_evt[BTN_MIDDLE] | em[EV_MIDDLE_DOWN]) & ~em[EV_MIDDLE_UP];
    end

    // next state and result
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        buttons_next   = buttons_reg;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        left_x_next    = left_x_reg;
        left_y_next    = left_y_reg;
        right_x_next   = right_x_reg;
        right_y_next   = right_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        hide_next      = hide_reg;
        res            = '0;

        unique case (item.command)
            CMD_EVENT:
            begin
                cur_x_next   = item.pos_x;
                cur_y_next   = item.pos_y;
                buttons_next = btn_evt;
                if (em[EV_LEFT_DOWN])
                begin
                    left_x_next   = item.pos_x;
                    left_y_next   = item.pos_y;
                    left_cnt_next = 16'(left_cnt_reg + 16'd1);
                end
                if (em[EV_RIGHT_DOWN])
                begin
                    right_x_next   = item.pos_x;
                    right_y_next   = item.pos_y;
                    right_cnt_next = 16'(right_cnt_reg + 16'd1);
                end
                if (hit != '0)
                begin
                    res.call_request  = 1'b1;
                    res.call_mask     = hit;
                    res.call_buttons  = btn_evt;
                    res.call_x        = item.pos_x;
                    res.call_y        = item.pos_y;
                    res.call_mickey_x = prod_x[15:0];
                    res.call_mickey_y = prod_y[15:0];
                end
            end
            CMD_RESET:
            begin
                cur_x_next     = '0;
                cur_y_next     = '0;
                buttons_next   = '0;
                left_cnt_next  = '0;
                right_cnt_next = '0;
                left_x_next    = '0;
                left_y_next    = '0;
                right_x_next   = '0;
                right_y_next   = '0;
                prev_x_next    = '0;
                prev_y_next    = '0;
                hide_next      = HIDE_RST;
                res.reg_a      = RESET_ANSWER_A;
                res.reg_b      = BUTTON_COUNT;
            end
            CMD_SHOW:
            begin
                if (hide_reg != '0)
                begin
                    hide_next = 16'(hide_reg - 16'd1);
                end
            end
            CMD_HIDE:
            begin
                if (hide_reg != HIDE_MAX)
                begin
                    hide_next = 16'(hide_reg + 16'd1);
                end
            end
            CMD_READ_POS:
            begin
                res.reg_b = {13'b0, buttons_reg};
                res.reg_c = cur_x_reg;
                res.reg_d = cur_y_reg;
            end
            CMD_READ_PRESS:
            begin
                res.reg_a = {13'b0, buttons_reg};
                if (item.button_select)
                begin
                    res.reg_b      = right_cnt_reg;
                    res.reg_c      = right_x_reg;
                    res.reg_d      = right_y_reg;
                    right_cnt_next = '0;
                end
                else
                begin
                    res.reg_b     = left_cnt_reg;
                    res.reg_c     = left_x_reg;
                    res.reg_d     = left_y_reg;
                    left_cnt_next = '0;
                end
            end
            CMD_READ_MOTION:
            begin
                res.reg_c   = prod_x[15:0];
                res.reg_d   = prod_y[15:0];
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
            end
            default:
            begin
                // unused command changes nothing
            end
        endcase

        res.cursor_shown = (hide_next == '0);
    end

    // state registers, updated when an item passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            buttons_reg   <= '0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            left_x_reg    <= '0;
            left_y_reg    <= '0;
            right_x_reg   <= '0;
            right_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            hide_reg      <= HIDE_RST;
        end
        else if (go)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            buttons_reg   <= buttons_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            left_x_reg    <= left_x_next;
            left_y_reg    <= left_y_next;
            right_x_reg   <= right_x_next;
            right_y_reg   <= right_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            hide_reg      <= hide_next;
        end
    end

endmodule

`default_nettype wire

>>> src/mdst_checker.sv
// port-level checks for the mouse state tracker, bound to the top level
// depends on mdst_pkg and mouse_driver_state_tracker_core_defines.svh
`default_nettype none
`include "mouse_driver_state_tracker_core_defines.svh"

module mdst_checker
    import mdst_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        evt_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input res_item_t        res_item
);

    logic reset_beat;
    logic reset_answer_ok;
    logic call_beat;
    logic call_answer_ok;

    // result beat classes and what each must carry
    assign reset_beat      = res_valid && (res_item.reg_a == RESET_ANSWER_A);
    assign reset_answer_ok = (res_item.reg_b == BUTTON_COUNT) && !res_item.cursor_shown
                             && !res_item.call_request;
    assign call_beat       = res_valid && res_item.call_request;
    assign call_answer_ok  = (res_item.call_mask != 7'd0) && (res_item.reg_a == 16'd0);

    // a held result keeps its payload
    `MDST_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item))

    // input stalls only when a finished result is waiting
    `MDST_ASSERT_IMP(a_stall_cause, evt_stall, res_valid && res_stall)

    // driver reset answer: button count, cursor hidden, no callback
    `MDST_ASSERT_IMP(a_reset_answer, reset_beat, reset_answer_ok)

    // a callback always carries a non-empty mask and a zero reg_a
    `MDST_ASSERT_IMP(a_call_mask, call_beat, call_answer_ok)

endmodule

bind mouse_driver_state_tracker_core mdst_checker u_mdst_checker (.*);

`default_nettype wire

>>> verif/tb_mouse_driver_state_tracker_core.sv
// self-checking testbench for mouse_driver_state_tracker_core: queued beats are
// driven with random gaps and stalls, and each result is checked against a local tracker
// depends on mdst_pkg and the core RTL
`default_nettype none

module tb_mouse_driver_state_tracker_core;
    import mdst_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int EV_MOVE = 0;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic evt_valid = 1'b0;
    logic evt_stall;
    evt_item_t evt_item = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_item_t res_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // local copy of the driver state and registers
    cfg_t trk_cfg;
    logic [15:0] cur_x, cur_y;
    logic [2:0] btn;
    logic [15:0] left_cnt, right_cnt;
    logic [15:0] left_px, left_py, right_px, right_py;
    logic [15:0] prev_x, prev_y;
    logic [15:0] hide_cnt;

    evt_item_t pending_items[$];
    res_item_t awaited_results[$];
    res_item_t oldest_want;

    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned events_seen = 0;
    int unsigned callbacks_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned hold_left = 0;
    logic hold_request = 1'b0;

    mouse_driver_state_tracker_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_item  (evt_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // driver state back to its reset values
    function automatic void clear_tracker();
        cur_x = '0;
        cur_y = '0;
        btn = '0;
        left_cnt = '0;
        right_cnt = '0;
        left_px = '0;
        left_py = '0;
        right_px = '0;
        right_py = '0;
        prev_x = '0;
        prev_y = '0;
        hide_cnt = HIDE_RST;
    endfunction

    // apply one beat to the local tracker and return the answer it produces
    function automatic res_item_t track_mouse(evt_item_t it);
        res_item_t r;
        logic [6:0] hit;
        logic [15:0] hm, vm, dx, dy;
        logic [31:0] prod_x, prod_y;
        r = '0;
        hm = trk_cfg.horiz_ratio >> RATIO_SHIFT;
        vm = trk_cfg.vert_ratio >> RATIO_SHIFT;
        case (it.command)
            CMD_EVENT:
            begin
                events_seen++;
                cur_x = it.pos_x;
                cur_y = it.pos_y;
                // down edge before up edge of the same button
                if (it.event_mask[EV_LEFT_DOWN])
                begin
                    btn[BTN_LEFT] = 1'b1;
                    left_px = it.pos_x;
                    left_py = it.pos_y;
                    left_cnt = left_cnt + 16'd1;
                end
                if (it.event_mask[EV_LEFT_UP])
                    btn[BTN_LEFT] = 1'b0;
                if (it.event_mask[EV_RIGHT_DOWN])
                begin
                    btn[BTN_RIGHT] = 1'b1;
                    right_px = it.pos_x;
                    right_py = it.pos_y;
                    right_cnt = right_cnt + 16'd1;
                end
                if (it.event_mask[EV_RIGHT_UP])
                    btn[BTN_RIGHT] = 1'b0;
                if (it.event_mask[EV_MIDDLE_DOWN])
                    btn[BTN_MIDDLE] = 1'b1;
                if (it.event_mask[EV_MIDDLE_UP])
                    btn[BTN_MIDDLE] = 1'b0;
                // callback with mickeys, low 16 bits
                hit = it.event_mask & trk_cfg.call_mask;
                if (hit != '0)
                begin
                    callbacks_seen++;
                    prod_x = 32'(cur_x) * 32'(hm);
                    prod_y = 32'(cur_y) * 32'(vm);
                    r.call_request = 1'b1;
                    r.call_mask = hit;
                    r.call_buttons = btn;
                    r.call_x = cur_x;
                    r.call_y = cur_y;
                    r.call_mickey_x = prod_x[15:0];
                    r.call_mickey_y = prod_y[15:0];
                end
            end
            CMD_RESET:
            begin
                clear_tracker();
                r.reg_a = RESET_ANSWER_A;
                r.reg_b = BUTTON_COUNT;
            end
            CMD_SHOW:
            begin
                if (hide_cnt != '0)
                    hide_cnt = hide_cnt - 16'd1;
            end
            CMD_HIDE:
            begin
                if (hide_cnt != HIDE_MAX)
                    hide_cnt = hide_cnt + 16'd1;
            end
            CMD_READ_POS:
            begin
                r.reg_b = {13'd0, btn};
                r.reg_c = cur_x;
                r.reg_d = cur_y;
            end
            CMD_READ_PRESS:
            begin
                // count of the selected button clears on read
                if (it.button_select)
                begin
                    r.reg_b = right_cnt;
                    r.reg_c = right_px;
                    r.reg_d = right_py;
                    right_cnt = '0;
                end
                else
                begin
                    r.reg_b = left_cnt;
                    r.reg_c = left_px;
                    r.reg_d = left_py;
                    left_cnt = '0;
                end
                r.reg_a = {13'd0, btn};
            end
            CMD_READ_MOTION:
            begin
                dx = cur_x - prev_x;
                dy = cur_y - prev_y;
                prod_x = 32'(dx) * 32'(hm);
                prod_y = 32'(dy) * 32'(vm);
                r.reg_c = prod_x[15:0];
                r.reg_d = prod_y[15:0];
                prev_x = cur_x;
                prev_y = cur_y;
            end
            default:
            begin
            end
        endcase
        r.cursor_shown = (hide_cnt == '0);
        return r;
    endfunction

    // input side: offer queued beats, hold them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
        end
        else
        begin
            if (evt_valid && !evt_stall)
            begin
                awaited_results.push_back(track_mouse(evt_item));
                items_accepted <= items_accepted + 1;
            end
            if (!evt_valid || !evt_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    evt_item <= pending_items.pop_front();
                    evt_valid <= 1'b1;
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // output side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= (hold_left != 0) || ($urandom_range(99) < recv_gap_pct);
    end

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         fname, results_checked, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result beat with nothing awaited: %p", res_item);
            end
            else
            begin
                oldest_want = awaited_results.pop_front();
                compare_field("reg_a", oldest_want.reg_a, res_item.reg_a);
                compare_field("reg_b", oldest_want.reg_b, res_item.reg_b);
                compare_field("reg_c", oldest_want.reg_c, res_item.reg_c);
                compare_field("reg_d", oldest_want.reg_d, res_item.reg_d);
                compare_field("cursor_shown", 16'(oldest_want.cursor_shown),
                              16'(res_item.cursor_shown));
                compare_field("call_request", 16'(oldest_want.call_request),
                              16'(res_item.call_request));
                compare_field("call_mask", 16'(oldest_want.call_mask),
                              16'(res_item.call_mask));
                compare_field("call_buttons", 16'(oldest_want.call_buttons),
                              16'(res_item.call_buttons));
                compare_field("call_x", oldest_want.call_x, res_item.call_x);
                compare_field("call_y", oldest_want.call_y, res_item.call_y);
                compare_field("call_mickey_x", oldest_want.call_mickey_x,
                              res_item.call_mickey_x);
                compare_field("call_mickey_y", oldest_want.call_mickey_y,
                              res_item.call_mickey_y);
            end
            results_checked++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_item(input evt_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [15:0] random_coord();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic evt_item_t make_event(input logic [15:0] x, input logic [15:0] y,
                                             input logic [6:0] emask);
        evt_item_t it;
        it.command = CMD_EVENT;
        it.pos_x = x;
        it.pos_y = y;
        it.event_mask = emask;
        it.button_select = 1'($urandom_range(1));
        return it;
    endfunction

    // command beat; unused fields carry random bits
    function automatic evt_item_t make_cmd(input logic [2:0] cmd, input logic sel);
        evt_item_t it;
        it.command = cmd;
        it.pos_x = random_coord();
        it.pos_y = random_coord();
        it.event_mask = 7'($urandom_range(127));
        it.button_select = sel;
        return it;
    endfunction

    task automatic queue_random(input int unsigned count);
        int unsigned pick;
        logic [2:0] cmd;
        logic [6:0] emask;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // half the time a single edge with a move, else any mix
                if ($urandom_range(1))
                    emask = 7'(1 << EV_MOVE) | 7'(1 << $urandom_range(6, 1));
                else
                    emask = 7'($urandom_range(127));
                queue_item(make_event(random_coord(), random_coord(), emask));
            end
            else
            begin
                if (pick < 57)
                    cmd = CMD_RESET;
                else if (pick < 63)
                    cmd = CMD_SHOW;
                else if (pick < 69)
                    cmd = CMD_HIDE;
                else if (pick < 78)
                    cmd = CMD_READ_POS;
                else if (pick < 88)
                    cmd = CMD_READ_PRESS;
                else if (pick < 98)
                    cmd = CMD_READ_MOTION;
                else
                    cmd = CMD_UNUSED;
                queue_item(make_cmd(cmd, 1'($urandom_range(1))));
            end
        end
    endtask

    // wait until every queued beat has its result back
    task automatic wait_idle();
        while (items_accepted != items_queued || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want_rd;
        want_rd = '0;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HORIZ_RATIO:
            begin
                trk_cfg.horiz_ratio = value[15:0];
                want_rd = {16'd0, value[15:0]};
            end
            REG_VERT_RATIO:
            begin
                trk_cfg.vert_ratio = value[15:0];
                want_rd = {16'd0, value[15:0]};
            end
            REG_CALL_MASK:
            begin
                trk_cfg.call_mask = value[6:0];
                want_rd = {25'd0, value[6:0]};
            end
            default: ;
        endcase
        // read the register back
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want_rd)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("register %0d read back: expected %h, got %h", idx, want_rd, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] h, input logic [15:0] v,
                              input logic [6:0] m);
        write_reg(REG_HORIZ_RATIO, {16'd0, h});
        write_reg(REG_VERT_RATIO, {16'd0, v});
        write_reg(REG_CALL_MASK, {25'd0, m});
    endtask

    // stimulus sequence
    initial
    begin
        clear_tracker();
        trk_cfg.horiz_ratio = HORIZ_RATIO_RST;
        trk_cfg.vert_ratio = VERT_RATIO_RST;
        trk_cfg.call_mask = CALL_MASK_RST;
        send_gap_pct = 11;
        recv_gap_pct = 55;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed beats under register defaults
        queue_item(make_cmd(CMD_READ_POS, 1'b0));
        queue_item(make_cmd(CMD_READ_MOTION, 1'b0));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b0));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b1));
        queue_item(make_cmd(CMD_SHOW, 1'b0));
        queue_item(make_cmd(CMD_SHOW, 1'b1));
        queue_item(make_cmd(CMD_HIDE, 1'b0));
        queue_item(make_cmd(CMD_SHOW, 1'b0));
        queue_item(make_event(16'hFFFF, 16'hFFFF, 7'h7F));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b0));
        queue_item(make_event(16'h0000, 16'h0000, 7'(1 << EV_LEFT_DOWN) | 7'(1 << EV_MOVE)));
        queue_item(make_event(16'h8000, 16'h0001, 7'(1 << EV_RIGHT_DOWN)));
        queue_item(make_event(16'h0001, 16'h7FFF, 7'(1 << EV_MIDDLE_DOWN)));
        queue_item(make_cmd(CMD_READ_POS, 1'b1));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b1));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b0));
        queue_item(make_cmd(CMD_READ_MOTION, 1'b1));
        queue_item(make_event(16'h0000, 16'h0000, 7'(1 << EV_LEFT_UP) | 7'(1 << EV_RIGHT_UP)
                              | 7'(1 << EV_MIDDLE_UP) | 7'(1 << EV_MOVE)));
        queue_item(make_cmd(CMD_READ_MOTION, 1'b0));
        queue_item(make_cmd(CMD_UNUSED, 1'b1));
        queue_item(make_cmd(CMD_RESET, 1'b0));
        queue_item(make_cmd(CMD_READ_POS, 1'b0));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b0));
        queue_item(make_cmd(CMD_READ_MOTION, 1'b0));
        wait_idle();

        // largest ratios, every event bit calls back
        set_config(16'hFFFF, 16'hFFFF, 7'h7F);
        queue_random(550);
        wait_idle();

        // sender slow, receiver fast; zero mickeys, move-only callbacks
        send_gap_pct = 55;
        recv_gap_pct = 11;
        set_config(16'h0000, 16'h0007, 7'h01);
        queue_random(550);
        wait_idle();

        // no gaps, with one long receiver hold-off to back the block up
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_config(16'd80, 16'd13, 7'h2A);
        queue_random(200);
        @(posedge clk) hold_request <= 1'b1;
        @(posedge clk) hold_request <= 1'b0;
        wait_idle();

        // hide counter floor, repeated presses, then a driver reset
        queue_item(make_cmd(CMD_RESET, 1'b0));
        repeat (3) queue_item(make_cmd(CMD_HIDE, 1'b0));
        repeat (6) queue_item(make_cmd(CMD_SHOW, 1'b0));
        repeat (5)
            queue_item(make_event(random_coord(), random_coord(),
                                  7'(1 << EV_LEFT_DOWN) | 7'(1 << EV_RIGHT_DOWN)));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b0));
        queue_item(make_cmd(CMD_READ_PRESS, 1'b1));
        queue_item(make_cmd(CMD_RESET, 1'b1));
        wait_idle();

        set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   7'($urandom_range(127, 1)));
        queue_random(310);
        wait_idle();

        $display("%0d beats checked (%0d mouse events, %0d callbacks) over five settings",
                 results_checked, events_seen, callbacks_seen);
        $display("covered gaps on either side, a long output hold-off and the hide floor");
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> mouse_driver_state_tracker_core.f
+incdir+src
src/mdst_pkg.sv
src/mdst_cfg.sv
src/mdst_track.sv
src/mouse_driver_state_tracker_core.sv
src/mdst_checker.sv
verif/tb_mouse_driver_state_tracker_core.sv
